// ===== hdl/tbc_pkg.sv =====
package tbc_pkg;

  // Field widths of the stream words
  localparam int TILT_W    = 17;
  localparam int GYRO_W    = 17;
  localparam int WHEEL_W   = 16;
  localparam int DRIVE_W   = 9;
  localparam int STEER_W   = 12;
  localparam int DUTY_W    = 13;
  localparam int SERVO_W   = 12;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 48;

  // Internal term widths (independent of the filter fraction)
  localparam int BALW = 28;   // balance PD term
  localparam int VELW = 30;   // velocity PI term
  localparam int SUMW = 31;   // main command before clamp

  // Fixed scalars
  localparam int KI_FRAC         = 16;
  localparam int SPEED_INT_LIMIT = 20000;
  localparam int PWM_FULL        = 7200;
  localparam int DUTY_OFFSET     = 100;
  localparam int DUTY_LIMIT_MAX  = 7100;
  localparam int DRIVE_SCALE     = 40;
  localparam int GYRO_OFFSET     = 40;
  localparam int TILT_LOW        = 15360;
  localparam int TILT_HIGH       = 30720;
  localparam int SERVO_BASE      = 2000;
  localparam int SERVO_OFFSET    = 125;

  // One result word
  typedef struct packed {
    logic               main_dir;
    logic [DUTY_W-1:0]  main_duty;
    logic               drive_dir;
    logic [DUTY_W-1:0]  drive_duty;
    logic [SERVO_W-1:0] servo_pulse;
    logic               tilt_ok;
  } res_t;

endpackage

// ===== hdl/tbc_mul.sv =====
module tbc_mul #(
  parameter int AW = 34,
  parameter int BW = 17
) (
  input  logic                     clk,
  input  logic signed [AW-1:0]     a_i,
  input  logic signed [BW-1:0]     b_i,
  output logic signed [AW+BW-1:0]  p_r
);

  // Shared signed multiplier, product registered
  always_ff @(posedge clk) begin
    p_r <= (AW+BW)'(a_i) * (AW+BW)'(b_i);
  end

endmodule

// ===== hdl/tbc_fmt.sv =====
module tbc_fmt (
  input  logic signed [tbc_pkg::SUMW-1:0]    cmd_i,
  input  logic        [tbc_pkg::DUTY_W-1:0]  limit_i,
  input  logic signed [tbc_pkg::DRIVE_W-1:0] drive_i,
  input  logic signed [tbc_pkg::STEER_W-1:0] steer_i,
  input  logic                               tilt_ok_i,
  output tbc_pkg::res_t                      res_o
);
  import tbc_pkg::*;

  logic        [DUTY_W-1:0]  lim;
  logic signed [SUMW-1:0]    lim_s;
  logic signed [SUMW-1:0]    main_c;
  logic signed [SUMW-1:0]    main_mag;
  logic signed [15:0]        lim16;
  logic signed [15:0]        drv_x;
  logic signed [15:0]        drv_c;
  logic signed [15:0]        drv_mag;
  logic signed [12:0]        half_t;
  logic signed [12:0]        half_s;
  logic signed [12:0]        sv_t;

  // Duty limit saturates so duties stay in range
  assign lim   = (limit_i > DUTY_W'(DUTY_LIMIT_MAX)) ? DUTY_W'(DUTY_LIMIT_MAX) : limit_i;
  assign lim_s = $signed(SUMW'(lim));
  assign lim16 = $signed(16'(lim));

  // Main motor: clamp, magnitude, offset
  always_comb begin
    priority if (cmd_i > lim_s) begin
      main_c = lim_s;
    end else if (cmd_i < -lim_s) begin
      main_c = -lim_s;
    end else begin
      main_c = cmd_i;
    end
  end
  assign main_mag = main_c[SUMW-1] ? -main_c : main_c;

  // Drive motor: scale, clamp, inverted duty when reversing
  assign drv_x = 16'(drive_i) * 16'(DRIVE_SCALE);
  always_comb begin
    priority if (drv_x > lim16) begin
      drv_c = lim16;
    end else if (drv_x < -lim16) begin
      drv_c = -lim16;
    end else begin
      drv_c = drv_x;
    end
  end
  assign drv_mag = drv_c[15] ? -drv_c : drv_c;

  // Servo: steer/2 rounds toward zero
  assign half_t = 13'(steer_i) + (steer_i[STEER_W-1] ? 13'sd1 : 13'sd0);
  assign half_s = half_t >>> 1;
  assign sv_t   = 13'(SERVO_BASE) - half_s - 13'(SERVO_OFFSET);

  always_comb begin
    res_o.main_dir    = ~main_c[SUMW-1];
    res_o.main_duty   = main_mag[DUTY_W-1:0] + DUTY_W'(DUTY_OFFSET);
    res_o.drive_dir   = drv_c[15];
    res_o.drive_duty  = drv_c[15] ? (DUTY_W'(PWM_FULL) - drv_mag[DUTY_W-1:0])
                                  : drv_mag[DUTY_W-1:0];
    res_o.servo_pulse = sv_t[SERVO_W-1:0];
    res_o.tilt_ok     = tilt_ok_i;
  end

endmodule

// ===== hdl/tilt_balance_cascade_pid_top.sv =====
// Cascaded balance controller, one control tick per input word.
// Input stream (in_*): one word carries tilt angle, gyro rate, encoder count,
// drive and steer commands. Output stream (out_*): one result word per input
// word with direction bits, motor duties, servo compare value and tilt flag.
// Config port (cfg_*): write-only gains, set point and duty limit; write only
// while no word is in flight.
// Structure: a single signed multiplier is shared by a sequencer that walks
// eleven steps (PD terms, filter, integral, PI terms, sum, format); a new
// input word is taken only when the sequencer is back in its idle step.
// The output word sits in its own register: the next input word is accepted
// while a result still waits. If the receiver stalls, the sequencer holds in
// its final step until the output register frees up.
// Reset (rst_n low, synchronous) restores the default registers and clears
// the speed filter and speed integral.
module tilt_balance_cascade_pid_top #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tilt_angle[16:0], gyro_rate[33:17], wheel_count[49:34], drive_cmd[58:50],
  // steer_cmd[70:59], zero pad[71]
  input  logic [tbc_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // main_dir[0], main_duty[13:1], drive_dir[14], drive_duty[27:15],
  // servo_pulse[39:28], tilt_ok[40], zero pad[47:41]
  output logic [tbc_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import tbc_pkg::*;

  localparam int F  = COEF_FRAC_BITS;
  localparam int FW = F + 18;                    // filtered speed
  localparam int IW = F + 16;                    // speed integral
  localparam int BW = (F + 1 > 17) ? F + 1 : 17; // gain operand
  localparam int PW = FW + BW;                   // product / accumulator

  localparam longint ONE_L  = longint'(1) << F;
  localparam longint CA_L   = ((longint'(65) << F) + 50) / 100;
  localparam longint CB_L   = ONE_L - CA_L;
  localparam longint HALF_L = ONE_L >> 1;
  localparam logic signed [FW:0] ILIM_P = (FW+1)'(longint'(SPEED_INT_LIMIT) << F);

  // Register indexes
  localparam logic [2:0] REG_CENTER = 3'd0;
  localparam logic [2:0] REG_BKP    = 3'd1;
  localparam logic [2:0] REG_BKD    = 3'd2;
  localparam logic [2:0] REG_SKP    = 3'd3;
  localparam logic [2:0] REG_SKI    = 3'd4;
  localparam logic [2:0] REG_LIMIT  = 3'd5;

  // Sequencer steps
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_BP   = 4'd1;
  localparam logic [3:0] S_BD   = 4'd2;
  localparam logic [3:0] S_FA   = 4'd3;
  localparam logic [3:0] S_FB   = 4'd4;
  localparam logic [3:0] S_FC   = 4'd5;
  localparam logic [3:0] S_INT  = 4'd6;
  localparam logic [3:0] S_VK   = 4'd7;
  localparam logic [3:0] S_VS   = 4'd8;
  localparam logic [3:0] S_VT   = 4'd9;
  localparam logic [3:0] S_SUM  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  // Configuration
  logic [14:0]       center_r;
  logic [11:0]       bkp_r;
  logic [7:0]        bkd_r;
  logic [9:0]        skp_r;
  logic [15:0]       ski_r;
  logic [DUTY_W-1:0] limit_r;

  // Latched input word
  logic signed [TILT_W-1:0]  angle_r;
  logic signed [GYRO_W-1:0]  gyro_r;
  logic signed [WHEEL_W-1:0] wheel_r;
  logic signed [DRIVE_W-1:0] drive_r;
  logic signed [STEER_W-1:0] steer_r;

  // Sequencer and datapath registers
  logic [3:0]             state_r, state_nxt;
  logic signed [PW-1:0]   acc_r, acc_nxt;
  logic signed [BALW-1:0] bal_r, bal_nxt;
  logic signed [FW-1:0]   filt_r, filt_nxt;
  logic signed [IW-1:0]   integ_r, integ_nxt;
  logic                   brnz_r, brnz_nxt;
  logic signed [VELW-1:0] vel_r, vel_nxt;
  logic signed [SUMW-1:0] sum_r, sum_nxt;
  logic                   ovalid_r, ovalid_nxt;
  res_t                   ores_r, ores_nxt;

  logic signed [FW-1:0]   mul_a;
  logic signed [BW-1:0]   mul_b;
  logic signed [PW-1:0]   prod_r;
  logic signed [PW-1:0]   bal_x;
  logic signed [PW-1:0]   bal_t;
  logic signed [PW-1:0]   filt_rnd;
  logic signed [FW:0]     isum;
  logic signed [PW-1:0]   s_sum;
  logic signed [PW-1:0]   vel_t;
  logic                   tilt_ok;
  logic                   in_fire;
  res_t                   fmt_res;

  // No word is taken while reset is held
  assign in_tready = rst_n && (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= 15'd23040;
      bkp_r    <= 12'd750;
      bkd_r    <= 8'd4;
      skp_r    <= 10'd50;
      ski_r    <= 16'd1311;
      limit_r  <= 13'd6900;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CENTER: center_r <= cfg_wdata[14:0];
        REG_BKP:    bkp_r    <= cfg_wdata[11:0];
        REG_BKD:    bkd_r    <= cfg_wdata[7:0];
        REG_SKP:    skp_r    <= cfg_wdata[9:0];
        REG_SKI:    ski_r    <= cfg_wdata;
        REG_LIMIT:  limit_r  <= cfg_wdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      angle_r <= in_tdata[16:0];
      gyro_r  <= in_tdata[33:17];
      wheel_r <= in_tdata[49:34];
      drive_r <= in_tdata[58:50];
      steer_r <= in_tdata[70:59];
    end
  end

  // Multiplier operand schedule
  always_comb begin
    unique case (state_r)
      S_BP: begin
        mul_a = FW'(angle_r) - FW'($signed({1'b0, center_r}));
        mul_b = $signed(BW'(bkp_r));
      end
      S_BD: begin
        mul_a = FW'(gyro_r) - FW'(GYRO_OFFSET);
        mul_b = $signed(BW'(bkd_r));
      end
      S_FA: begin
        mul_a = filt_r;
        mul_b = BW'(CA_L);
      end
      S_FB: begin
        mul_a = FW'(wheel_r);
        mul_b = BW'(CB_L);
      end
      S_INT: begin
        mul_a = filt_r;
        mul_b = $signed(BW'(skp_r));
      end
      S_VK: begin
        mul_a = FW'(integ_r);
        mul_b = $signed(BW'(ski_r));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  tbc_mul #(
    .AW (FW),
    .BW (BW)
  ) u_mul (
    .clk (clk),
    .a_i (mul_a),
    .b_i (mul_b),
    .p_r (prod_r)
  );

  // Balance term: truncate toward zero
  assign bal_x = acc_r + (prod_r <<< 8);
  assign bal_t = bal_x + (bal_x[PW-1] ? PW'(255) : '0);

  // Filter rounding, integral sum
  assign filt_rnd = prod_r + PW'(HALF_L);
  assign isum     = (FW+1)'(integ_r) + (FW+1)'(filt_r);

  // Velocity term: fold integral part in, then truncate toward zero
  assign s_sum = acc_r + (prod_r >>> KI_FRAC);
  assign vel_t = acc_r + (acc_r[PW-1] ? (PW'(ONE_L - 1) + PW'(brnz_r)) : '0);

  assign tilt_ok = (angle_r > TILT_LOW) && (angle_r < TILT_HIGH);

  tbc_fmt u_fmt (
    .cmd_i     (sum_r),
    .limit_i   (limit_r),
    .drive_i   (drive_r),
    .steer_i   (steer_r),
    .tilt_ok_i (tilt_ok),
    .res_o     (fmt_res)
  );

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    acc_nxt    = acc_r;
    bal_nxt    = bal_r;
    filt_nxt   = filt_r;
    integ_nxt  = integ_r;
    brnz_nxt   = brnz_r;
    vel_nxt    = vel_r;
    sum_nxt    = sum_r;
    ovalid_nxt = ovalid_r && !out_tready;
    ores_nxt   = ores_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_BP;
      end
      S_BP: state_nxt = S_BD;
      S_BD: begin
        acc_nxt   = prod_r;
        state_nxt = S_FA;
      end
      S_FA: begin
        bal_nxt   = BALW'(bal_t >>> 8);
        state_nxt = S_FB;
      end
      S_FB: begin
        filt_nxt  = FW'(filt_rnd >>> F);
        state_nxt = S_FC;
      end
      S_FC: begin
        filt_nxt  = filt_r + FW'(prod_r);
        state_nxt = S_INT;
      end
      S_INT: begin
        priority if (isum > ILIM_P) begin
          integ_nxt = IW'(ILIM_P);
        end else if (isum < -ILIM_P) begin
          integ_nxt = IW'(-ILIM_P);
        end else begin
          integ_nxt = IW'(isum);
        end
        state_nxt = S_VK;
      end
      S_VK: begin
        acc_nxt   = prod_r;
        state_nxt = S_VS;
      end
      S_VS: begin
        acc_nxt   = s_sum;
        brnz_nxt  = |prod_r[KI_FRAC-1:0];
        state_nxt = S_VT;
      end
      S_VT: begin
        vel_nxt   = VELW'(vel_t >>> F);
        state_nxt = S_SUM;
      end
      S_SUM: begin
        sum_nxt   = tilt_ok ? (SUMW'(bal_r) + SUMW'(vel_r)) : '0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          ores_nxt   = fmt_res;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      filt_r   <= '0;
      integ_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      filt_r   <= filt_nxt;
      integ_r  <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    bal_r  <= bal_nxt;
    brnz_r <= brnz_nxt;
    vel_r  <= vel_nxt;
    sum_r  <= sum_nxt;
    ores_r <= ores_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {7'd0, ores_r.tilt_ok, ores_r.servo_pulse, ores_r.drive_duty,
                       ores_r.drive_dir, ores_r.main_duty, ores_r.main_dir};

`ifndef ASSERT_OFF
  // Accepted word starts the multiply schedule
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_BP)
    else $error("sequencer did not start after accept");

  // Integral stays inside its clamp
  a_integ: assert property (@(posedge clk) disable iff (!rst_n)
    ((FW+1)'(integ_r) <= ILIM_P) && ((FW+1)'(integ_r) >= -ILIM_P))
    else $error("speed integral out of range");

  // Tilt out of window gives zero main command
  a_tilt: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !ores_r.tilt_ok) |->
      (ores_r.main_dir && ores_r.main_duty == DUTY_W'(DUTY_OFFSET)))
    else $error("main command not zero outside tilt window");

  // Main duty within offset and full scale
  a_duty: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> (ores_r.main_duty >= DUTY_W'(DUTY_OFFSET)) &&
                 (ores_r.main_duty <= DUTY_W'(PWM_FULL)))
    else $error("main duty out of range");

  // Result register loads only in the final step
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovalid_r) |-> $past(state_r) == S_OUT)
    else $error("result word appeared outside final step");
`endif

endmodule
